// ===== rtl/htfc_pkg.sv =====
// ----------------------------------------------------------------------------
// htfc_pkg: shared definitions for the humidity/temperature frame checker
// Frame byte positions, CRC-8 constants, status codes and the CRC fold.
// ----------------------------------------------------------------------------
package htfc_pkg;

   // CRC-8, polynomial x^8 + x^5 + x^4 + 1, preset to all ones.
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // Byte positions inside the six-byte measurement frame.
   localparam logic [2:0] POS_TEMP_MSB = 3'd0;
   localparam logic [2:0] POS_TEMP_LSB = 3'd1;
   localparam logic [2:0] POS_TEMP_CRC = 3'd2;
   localparam logic [2:0] POS_HUM_MSB  = 3'd3;
   localparam logic [2:0] POS_HUM_LSB  = 3'd4;
   localparam logic [2:0] POS_HUM_CRC  = 3'd5;

   // Conversion scales, in hundredths, and the temperature offset.
   localparam logic [14:0] TEMP_SPAN   = 15'd17500;
   localparam logic [13:0] HUM_SPAN    = 14'd10000;
   localparam logic [15:0] TEMP_OFFSET = 16'd4500;
   localparam logic [16:0] RAW_FULL    = 17'd65535;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TEMP_BAD = 2'd1,
      STATUS_HUM_BAD  = 2'd2
   } frame_status_type;

   // One byte folded into the CRC, MSB first.
   function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/humidity_temperature_frame_checker_core.sv =====
// ----------------------------------------------------------------------------
// humidity_temperature_frame_checker_core
// Checks the two CRC bytes of a six-byte sensor measurement frame and
// converts the raw temperature and humidity words to hundredths.
// ----------------------------------------------------------------------------
// Usage:
// Frame bytes enter on the req_ stream, one byte per transaction, in the order
// temperature MSB, LSB, CRC, humidity MSB, LSB, CRC. req_tuser high marks the
// first byte of a frame and restarts the byte count; without it the count
// wraps after the sixth byte, so back-to-back frames need no marker.
// The sixth byte produces one transaction on the rsp_ stream carrying the
// status (ok, temperature CRC bad, humidity CRC bad; temperature wins when
// both fail), both converted values (zero on error) and both raw words.
// Throughput is one byte per cycle while the output is not stalled. After its
// sixth byte is accepted, a result passes the product stage (CRC compare and
// scaling multiply), then the output register (divide-by-65535 correction).
// The whole pipeline advances together: while a result waits on a low
// rsp_tready, req_tready is low and nothing moves, and nothing is dropped.
// Reset clears the byte count, the CRC preset and all valid flags.
// ----------------------------------------------------------------------------
module humidity_temperature_frame_checker_core (
   input  logic        clock,
   input  logic        reset,
   // Input byte stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] frame_start
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi,
                                    // [44:29] temperature_raw, [60:45] humidity_raw,
                                    // [63:61] zero
   output logic [1:0]  rsp_tuser    // [1:0] frame_status
);

   // Frame tracking state.
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] temp_word_ff, temp_word_in;
   logic [15:0] hum_word_ff, hum_word_in;
   logic        temp_bad_ff, temp_bad_in;

   // Product stage.
   logic        s1_valid_ff, s1_valid_in;
   htfc_pkg::frame_status_type s1_status_ff, s1_status_in;
   logic [30:0] s1_temp_prod_ff;
   logic [29:0] s1_hum_prod_ff;
   logic [15:0] s1_temp_raw_ff;
   logic [15:0] s1_hum_raw_ff;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   htfc_pkg::frame_status_type rsp_status_ff;
   logic [63:0] rsp_data_ff, rsp_data_in;

   logic        advance;
   logic        req_fire;
   logic [2:0]  pos_eff;
   logic        last_byte;
   htfc_pkg::frame_status_type frame_status;

   // Divide-by-65535 for the output stage: p = q0*65535 + (q0 + lo).
   logic [14:0] temp_q0;
   logic [16:0] temp_rem;
   logic [14:0] temp_q;
   logic [15:0] temp_centi;
   logic [13:0] hum_q0;
   logic [16:0] hum_rem;
   logic [13:0] hum_q;
   logic        result_ok;

   // The whole pipeline moves when the output register is free or drains.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign req_fire   = req_tvalid && advance;

   // A start marker, or a position that cannot occur, means byte 0.
   assign pos_eff   = (req_tuser || pos_ff > htfc_pkg::POS_HUM_CRC) ?
                      htfc_pkg::POS_TEMP_MSB : pos_ff;
   assign last_byte = (pos_eff == htfc_pkg::POS_HUM_CRC);

   always_comb begin
      if (temp_bad_ff) begin
         frame_status = htfc_pkg::STATUS_TEMP_BAD;
      end else if (crc_ff != req_tdata) begin
         frame_status = htfc_pkg::STATUS_HUM_BAD;
      end else begin
         frame_status = htfc_pkg::STATUS_OK;
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      temp_word_in = temp_word_ff;
      hum_word_in  = hum_word_ff;
      temp_bad_in  = temp_bad_ff;
      if (req_fire) begin
         pos_in = last_byte ? htfc_pkg::POS_TEMP_MSB : pos_eff + 3'd1;
         case (pos_eff)
            htfc_pkg::POS_TEMP_MSB: begin
               crc_in       = htfc_pkg::crc_fold(htfc_pkg::CRC_INIT, req_tdata);
               temp_word_in = {req_tdata, temp_word_ff[7:0]};
            end
            htfc_pkg::POS_TEMP_LSB: begin
               crc_in       = htfc_pkg::crc_fold(crc_ff, req_tdata);
               temp_word_in = {temp_word_ff[15:8], req_tdata};
            end
            htfc_pkg::POS_TEMP_CRC: begin
               temp_bad_in = (crc_ff != req_tdata);
               crc_in      = htfc_pkg::CRC_INIT;
            end
            htfc_pkg::POS_HUM_MSB: begin
               crc_in      = htfc_pkg::crc_fold(htfc_pkg::CRC_INIT, req_tdata);
               hum_word_in = {req_tdata, hum_word_ff[7:0]};
            end
            htfc_pkg::POS_HUM_LSB: begin
               crc_in      = htfc_pkg::crc_fold(crc_ff, req_tdata);
               hum_word_in = {hum_word_ff[15:8], req_tdata};
            end
            default: begin
               crc_in = htfc_pkg::CRC_INIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= htfc_pkg::POS_TEMP_MSB;
         crc_ff       <= htfc_pkg::CRC_INIT;
         temp_word_ff <= '0;
         hum_word_ff  <= '0;
         temp_bad_ff  <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         temp_word_ff <= temp_word_in;
         hum_word_ff  <= hum_word_in;
         temp_bad_ff  <= temp_bad_in;
      end
   end

   // Product stage: the raw words are complete when the last byte arrives,
   // so the scaling multiplies work straight from the word registers.
   assign s1_valid_in  = advance ? (req_fire && last_byte) : s1_valid_ff;
   assign s1_status_in = frame_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && last_byte) begin
         s1_status_ff    <= s1_status_in;
         s1_temp_prod_ff <= 31'(temp_word_ff) * 31'(htfc_pkg::TEMP_SPAN);
         s1_hum_prod_ff  <= 30'(hum_word_ff) * 30'(htfc_pkg::HUM_SPAN);
         s1_temp_raw_ff  <= temp_word_ff;
         s1_hum_raw_ff   <= hum_word_ff;
      end
   end

   // Output stage: the remainder q0 + lo stays below twice 65535, so one
   // compare corrects the quotient.
   assign temp_q0    = s1_temp_prod_ff[30:16];
   assign temp_rem   = 17'(s1_temp_prod_ff[15:0]) + 17'(temp_q0);
   assign temp_q     = temp_q0 + 15'(temp_rem >= htfc_pkg::RAW_FULL);
   assign temp_centi = 16'(temp_q) - htfc_pkg::TEMP_OFFSET;

   assign hum_q0  = s1_hum_prod_ff[29:16];
   assign hum_rem = 17'(s1_hum_prod_ff[15:0]) + 17'(hum_q0);
   assign hum_q   = hum_q0 + 14'(hum_rem >= htfc_pkg::RAW_FULL);

   assign result_ok = (s1_status_ff == htfc_pkg::STATUS_OK);

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[14:0]  = result_ok ? temp_centi[14:0] : 15'd0;
      rsp_data_in[28:15] = result_ok ? hum_q : 14'd0;
      rsp_data_in[44:29] = s1_temp_raw_ff;
      rsp_data_in[60:45] = s1_hum_raw_ff;
   end

   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_status_ff <= s1_status_ff;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== tb/humidity_temperature_frame_checker_core_test.sv =====
// ----------------------------------------------------------------------------
// humidity_temperature_frame_checker_core_test: self-checking frame bench
// Streams six-byte measurement frames into the checker and compares every
// result, field by field, with a cycle-free model of the CRC check and the
// conversion. A short table of frames comes first, then random frames.
// ----------------------------------------------------------------------------
module humidity_temperature_frame_checker_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 7;
   // About 700 frame bytes in total; the table supplies the first 25.
   localparam int RANDOM_BYTES = 675;
   localparam int PHASE_COUNT  = 4;
   // After the last expected result the run stays open for SETTLE_CYCLES, so
   // that a stray extra result is still seen.
   localparam int SETTLE_CYCLES = 16;
   // In a correct run, spells without any transaction come only from a random
   // gap or stall run at 66 percent; this limit is far beyond such runs and
   // only trips on a hung handshake.
   localparam int STUCK_LIMIT = 4000;
   localparam int REPORT_LIMIT = 10;

   // One checker result as the model predicts it.
   typedef struct packed {
      htfc_pkg::frame_status_type status;
      logic signed [14:0] temp_centi;
      logic        [13:0] hum_centi;
      logic        [15:0] temp_raw;
      logic        [15:0] hum_raw;
   } measurement_type;

   // One row of the directed table. Rows with typed set carry a result that
   // is written out by hand; the others are checked against the model.
   typedef struct packed {
      logic [7:0]      data;
      logic            sof;
      logic            typed;
      measurement_type want;
   } stim_row_type;

   localparam measurement_type NO_RESULT = '0;
   // All-zero words with matching CRCs: the bottom of both scales.
   localparam measurement_type ZERO_OK =
      '{htfc_pkg::STATUS_OK, -15'sd4500, 14'd0, 16'h0000, 16'h0000};
   // All-ones words with matching CRCs: the top of both scales.
   localparam measurement_type FULL_OK =
      '{htfc_pkg::STATUS_OK, 15'sd13000, 14'd10000, 16'hFFFF, 16'hFFFF};
   // Both CRCs wrong: the temperature failure wins, values read zero.
   localparam measurement_type BOTH_BAD =
      '{htfc_pkg::STATUS_TEMP_BAD, 15'sd0, 14'd0, 16'hFFFF, 16'hFFFF};
   // Only the humidity CRC wrong.
   localparam measurement_type HUM_BAD_ZERO =
      '{htfc_pkg::STATUS_HUM_BAD, 15'sd0, 14'd0, 16'h0000, 16'h0000};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] rx_byte
   logic        req_tuser = 1'b0;    // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // [14:0] temperature_centi, [28:15] humidity_centi,
                                     // [44:29] temperature_raw, [60:45] humidity_raw
   logic [1:0]  rsp_tuser;           // [1:0] frame_status

   // Model state: where the next byte lands, the running CRC of the word
   // being received, both words and the temperature CRC verdict.
   logic [2:0]  frame_pos     = htfc_pkg::POS_TEMP_MSB;
   logic [7:0]  run_crc       = htfc_pkg::CRC_INIT;
   logic [15:0] temp_word     = '0;
   logic [15:0] hum_word      = '0;
   logic        temp_crc_bad  = 1'b0;

   measurement_type expected_readings [$];
   stim_row_type    plan [25];

   // Percent of cycles in which the sender holds back or the receiver stalls.
   int send_idle_pct = 0;
   int stall_pct     = 0;

   int bytes_sent    = 0;
   int random_bytes  = 0;
   int results_seen  = 0;
   int ok_frames     = 0;
   int temp_fail_frames = 0;
   int hum_fail_frames  = 0;
   int error_count   = 0;
   int stuck_cycles  = 0;

   humidity_temperature_frame_checker_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // CRC-8, polynomial 0x31, one byte shifted in most significant bit first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] d);
      logic [7:0] r;
      r = acc ^ d;
      repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? htfc_pkg::CRC_POLY : 8'h00);
      return r;
   endfunction

   // Random measurement word, with the two ends of the range favored.
   function automatic logic [15:0] pick_word();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   // Advances the model by one accepted byte. When the byte closes a frame,
   // frame_done is set and reading holds the result the checker must emit.
   task automatic advance_frame(input logic [7:0] b, input logic sof,
                                output bit frame_done, output measurement_type reading);
      logic [2:0]  slot;
      logic        hum_crc_bad;
      int unsigned scaled_t;
      int unsigned scaled_h;
      frame_done = 1'b0;
      reading = NO_RESULT;
      // A start marker always restarts the frame; a position past the last
      // byte cannot occur but would also be taken as the first byte.
      slot = (sof || frame_pos > htfc_pkg::POS_HUM_CRC) ? htfc_pkg::POS_TEMP_MSB : frame_pos;
      case (slot)
         htfc_pkg::POS_TEMP_MSB: begin
            run_crc = crc8_byte(htfc_pkg::CRC_INIT, b);
            temp_word[15:8] = b;
         end
         htfc_pkg::POS_TEMP_LSB: begin
            run_crc = crc8_byte(run_crc, b);
            temp_word[7:0] = b;
         end
         htfc_pkg::POS_TEMP_CRC: begin
            temp_crc_bad = (run_crc != b);
            run_crc = htfc_pkg::CRC_INIT;
         end
         htfc_pkg::POS_HUM_MSB: begin
            run_crc = crc8_byte(htfc_pkg::CRC_INIT, b);
            hum_word[15:8] = b;
         end
         htfc_pkg::POS_HUM_LSB: begin
            run_crc = crc8_byte(run_crc, b);
            hum_word[7:0] = b;
         end
         default: begin
            hum_crc_bad = (run_crc != b);
            reading.temp_raw = temp_word;
            reading.hum_raw  = hum_word;
            if (temp_crc_bad) begin
               reading.status = htfc_pkg::STATUS_TEMP_BAD;
            end else if (hum_crc_bad) begin
               reading.status = htfc_pkg::STATUS_HUM_BAD;
            end else begin
               reading.status = htfc_pkg::STATUS_OK;
               // Exact products divided by full scale, rounded down.
               scaled_t = (32'(temp_word) * 32'(htfc_pkg::TEMP_SPAN))
                          / 32'(htfc_pkg::RAW_FULL);
               scaled_h = (32'(hum_word) * 32'(htfc_pkg::HUM_SPAN))
                          / 32'(htfc_pkg::RAW_FULL);
               reading.temp_centi = 15'(int'(scaled_t) - int'(htfc_pkg::TEMP_OFFSET));
               reading.hum_centi  = 14'(scaled_h);
            end
            frame_done = 1'b1;
            run_crc = htfc_pkg::CRC_INIT;
         end
      endcase
      frame_pos = (slot >= htfc_pkg::POS_HUM_CRC) ? htfc_pkg::POS_TEMP_MSB : slot + 3'd1;
   endtask

   // Offers one byte, holding back first at the current idle rate, and waits
   // for the transaction. The accepted byte then advances the model; a typed
   // result replaces the model's prediction for that frame.
   task automatic send_byte(input logic [7:0] b, input logic sof,
                            input logic typed, input measurement_type want);
      bit              frame_done;
      measurement_type reading;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_frame(b, sof, frame_done, reading);
      if (frame_done) expected_readings.push_back(typed ? want : reading);
      bytes_sent++;
   endtask

   // Mostly well-formed frames with random words and, now and then, a bad
   // CRC. The rest are cut-off frames and bursts of random bytes, which the
   // checker must follow through its wrapping byte count.
   task automatic send_random_frame();
      logic [15:0] tw;
      logic [15:0] hw;
      logic [7:0]  tc;
      logic [7:0]  hc;
      logic [7:0]  fb [6];
      logic        lead_sof;
      int          kind;
      int          n_send;
      tw = pick_word();
      hw = pick_word();
      tc = crc8_byte(crc8_byte(htfc_pkg::CRC_INIT, tw[15:8]), tw[7:0]);
      hc = crc8_byte(crc8_byte(htfc_pkg::CRC_INIT, hw[15:8]), hw[7:0]);
      if ($urandom_range(99) < 15) tc = tc ^ 8'($urandom_range(255, 1));
      if ($urandom_range(99) < 15) hc = hc ^ 8'($urandom_range(255, 1));
      fb = '{tw[15:8], tw[7:0], tc, hw[15:8], hw[7:0], hc};
      lead_sof = 1'($urandom_range(1));
      kind = $urandom_range(99);
      if (kind < 6) begin
         n_send = $urandom_range(8, 1);
         repeat (n_send) begin
            send_byte(8'($urandom_range(255)), ($urandom_range(3) == 0), 1'b0, NO_RESULT);
         end
      end else begin
         n_send = (kind < 12) ? $urandom_range(5, 1) : 6;
         for (int i = 0; i < n_send; i++) begin
            send_byte(fb[i], (i == 0) && lead_sof, 1'b0, NO_RESULT);
         end
      end
      random_bytes += n_send;
   endtask

   task automatic report_field(input string field, input longint want, input longint got);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
      end
   endtask

   // Result side: every result transaction is checked against the oldest
   // prediction, then the next ready is drawn at the current stall rate.
   always @(posedge clock) begin
      measurement_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_readings.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("result %0d arrived with no frame outstanding", results_seen);
               end
            end else begin
               want = expected_readings.pop_front();
               case (want.status)
                  htfc_pkg::STATUS_OK:       ok_frames++;
                  htfc_pkg::STATUS_TEMP_BAD: temp_fail_frames++;
                  default:                   hum_fail_frames++;
               endcase
               if (rsp_tuser !== want.status) begin
                  report_field("frame_status", want.status, rsp_tuser);
               end
               if (rsp_tdata[14:0] !== want.temp_centi) begin
                  report_field("temperature_centi", want.temp_centi,
                               $signed(rsp_tdata[14:0]));
               end
               if (rsp_tdata[28:15] !== want.hum_centi) begin
                  report_field("humidity_centi", want.hum_centi, rsp_tdata[28:15]);
               end
               if (rsp_tdata[44:29] !== want.temp_raw) begin
                  report_field("temperature_raw", want.temp_raw, rsp_tdata[44:29]);
               end
               if (rsp_tdata[60:45] !== want.hum_raw) begin
                  report_field("humidity_raw", want.hum_raw, rsp_tdata[60:45]);
               end
               if (rsp_tdata[63:61] !== 3'b000) begin
                  report_field("padding", 0, rsp_tdata[63:61]);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: a long run of cycles without any transaction on either side
   // means the handshake has hung.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("no transaction for %0d cycles, %0d results still outstanding",
                  stuck_cycles, expected_readings.size());
         $display("FAIL humidity_temperature_frame_checker_core");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      // Directed frames. The first carries a start marker, the next two rely
      // on the byte count wrapping, then a lone marked byte opens a frame
      // that the following marker abandons.
      plan = '{
         '{8'h00, 1'b1, 1'b0, NO_RESULT},
         '{8'h00, 1'b0, 1'b0, NO_RESULT},
         '{8'h81, 1'b0, 1'b0, NO_RESULT},
         '{8'h00, 1'b0, 1'b0, NO_RESULT},
         '{8'h00, 1'b0, 1'b0, NO_RESULT},
         '{8'h81, 1'b0, 1'b1, ZERO_OK},
         '{8'hFF, 1'b0, 1'b0, NO_RESULT},
         '{8'hFF, 1'b0, 1'b0, NO_RESULT},
         '{8'hAC, 1'b0, 1'b0, NO_RESULT},
         '{8'hFF, 1'b0, 1'b0, NO_RESULT},
         '{8'hFF, 1'b0, 1'b0, NO_RESULT},
         '{8'hAC, 1'b0, 1'b1, FULL_OK},
         '{8'hFF, 1'b0, 1'b0, NO_RESULT},
         '{8'hFF, 1'b0, 1'b0, NO_RESULT},
         '{8'h00, 1'b0, 1'b0, NO_RESULT},
         '{8'hFF, 1'b0, 1'b0, NO_RESULT},
         '{8'hFF, 1'b0, 1'b0, NO_RESULT},
         '{8'h00, 1'b0, 1'b1, BOTH_BAD},
         '{8'h5A, 1'b1, 1'b0, NO_RESULT},
         '{8'h00, 1'b1, 1'b0, NO_RESULT},
         '{8'h00, 1'b0, 1'b0, NO_RESULT},
         '{8'h81, 1'b0, 1'b0, NO_RESULT},
         '{8'h00, 1'b0, 1'b0, NO_RESULT},
         '{8'h00, 1'b0, 1'b0, NO_RESULT},
         '{8'h7E, 1'b0, 1'b1, HUM_BAD_ZERO}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Four handshake mixes: free flowing, sparse sender, stalling
      // receiver, and light idling on both sides.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 66; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 66; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
         endcase
         if (phase == 0) begin
            foreach (plan[i]) send_byte(plan[i].data, plan[i].sof, plan[i].typed, plan[i].want);
         end
         while (random_bytes < RANDOM_BYTES * (phase + 1) / PHASE_COUNT) send_random_frame();
         // The sender holds off until every frame sent so far is answered.
         req_tvalid <= 1'b0;
         while (expected_readings.size() != 0) @(posedge clock);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d frame bytes under four handshake mixes, %0d results checked:",
               bytes_sent, results_seen);
      $display("  %0d good, %0d temperature CRC failures, %0d humidity CRC failures",
               ok_frames, temp_fail_frames, hum_fail_frames);
      if (error_count == 0 && expected_readings.size() == 0) begin
         $display("PASS humidity_temperature_frame_checker_core");
      end else begin
         $display("%0d errors, %0d results missing", error_count, expected_readings.size());
         $display("FAIL humidity_temperature_frame_checker_core");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/htfc_pkg.sv
rtl/humidity_temperature_frame_checker_core.sv
tb/humidity_temperature_frame_checker_core_test.sv
